@@ sv/stli_pkg.sv @@
// Shared types and constants of the sorted-table interpolator.
package stli_pkg;
    localparam int unsigned ENERGY_W = 24;
    localparam int unsigned PULSE_W  = 32;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [2:0] {
        ST_INTERP   = 3'd0,
        ST_LOW      = 3'd1,
        ST_HIGH     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_INSERTED = 3'd4,
        ST_DROPPED  = 3'd5
    } t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_item;    // capture input item
        logic wr_shift;     // write moved entry
        logic wr_new;       // write new point
        logic cap_lo;       // capture read data as lower point
        logic cap_hi;       // capture read data as upper point
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic rd_gt;        // read energy > item energy
        logic div_done;
    } t_stat;
endpackage

@@ sv/stli_if.sv @@
// Valid/ready channel interfaces of the interpolator.
interface stli_in_if;
    import stli_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [ENERGY_W-1:0]        energy;
    logic signed [PULSE_W-1:0]  pulse_value;
    modport source (output valid, opcode, energy, pulse_value, input ready);
    modport sink   (input valid, opcode, energy, pulse_value, output ready);
endinterface

interface stli_out_if;
    import stli_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [PULSE_W-1:0]  pulse_out;
    logic [STATUS_W-1:0]        status;
    logic [6:0]                 entry_count;
    logic                       table_nonempty;
    modport source (output valid, pulse_out, status, entry_count, table_nonempty,
                    input ready);
    modport sink   (input valid, pulse_out, status, entry_count, table_nonempty,
                    output ready);
endinterface

@@ sv/stli_ram.sv @@
// Generic single-port-write, registered-read RAM.
module stli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/stli_div.sv @@
// Restoring divider: 64-bit signed dividend by positive 25-bit divisor, truncating.
module stli_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [24:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    logic [63:0] r_q, n_q;
    logic [25:0] r_rem, n_rem;
    logic [24:0] r_den;
    logic        r_neg, r_busy;
    logic [6:0]  r_cnt;
    logic [25:0] w_trial;
    logic [63:0] w_q_signed;

    always_comb begin
        w_trial = {r_rem[24:0], r_q[63]};
        n_q     = {r_q[62:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
        w_q_signed = r_neg ? (~r_q + 64'd1) : r_q;
    end
    assign o_quot = w_q_signed[31:0];

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd0;
            r_neg  <= i_num[63];
            r_q    <= i_num[63] ? (~i_num + 64'd1) : i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
endmodule

@@ sv/stli_datapath.sv @@
// Datapath: point memories, item registers, interpolation arithmetic and divider.
module stli_datapath
    import stli_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic                     i_opcode,
    input  logic [ENERGY_W-1:0]      i_energy,
    input  logic signed [PULSE_W-1:0] i_pulse_value,
    output t_stat                    o_stat,
    output logic signed [PULSE_W-1:0] o_rd_pulse,
    output logic signed [PULSE_W-1:0] o_quot,
    output logic                     o_opcode
);
    logic [ENERGY_W-1:0]       r_e, rd_e, r_e0, r_e1, wd_e;
    logic signed [PULSE_W-1:0] r_p, rd_p, r_p0, r_p1, wd_p;
    logic                      r_op, w_we;
    logic signed [63:0]        r_sum;
    logic [24:0]               w_den;
    logic signed [64:0]        w_prod0, w_prod1;
    logic                      w_div_done;

    assign w_we = i_cmd.wr_shift | i_cmd.wr_new;
    assign wd_e = i_cmd.wr_new ? r_e : rd_e;
    assign wd_p = i_cmd.wr_new ? r_p : rd_p;

    stli_ram #(.WIDTH(ENERGY_W), .DEPTH(DEPTH)) u_eram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_waddr), .i_wdata(wd_e),
        .i_raddr(i_addr), .o_rdata(rd_e));
    stli_ram #(.WIDTH(PULSE_W), .DEPTH(DEPTH)) u_pram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_waddr), .i_wdata(wd_p),
        .i_raddr(i_addr), .o_rdata(rd_p));

    assign w_den = {1'b0, r_e1} - {1'b0, r_e0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_e  <= i_energy;
            r_p  <= i_pulse_value;
            r_op <= i_opcode;
        end
        if (i_cmd.cap_lo) begin
            r_e0 <= rd_e;
            r_p0 <= rd_p;
        end
        if (i_cmd.cap_hi) begin
            r_e1 <= rd_e;
            r_p1 <= rd_p;
        end
    end

    // p0*den + (p1-p0)*(x-e0), products of 32x26 and 33x26 bits, registered before divide
    logic signed [32:0] w_diff;
    logic signed [25:0] w_dens, w_nums;
    assign w_diff  = {r_p1[31], r_p1} - {r_p0[31], r_p0};
    assign w_dens  = {1'b0, w_den};
    assign w_nums  = {2'b00, r_e} - {2'b00, r_e0};
    assign w_prod0 = 65'(r_p0) * 65'(w_dens);
    assign w_prod1 = 65'(w_diff) * 65'(w_nums);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_hi) r_sum <= '0;
        else r_sum <= 64'(w_prod0 + w_prod1);
    end

    stli_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_sum), .i_den(w_den), .o_done(w_div_done), .o_quot(o_quot));

    assign o_stat       = {(rd_e > r_e), w_div_done};
    assign o_rd_pulse   = rd_p;
    assign o_opcode     = r_op;
endmodule

@@ sv/stli_ctrl.sv @@
// Controller: sequences insert shift, lookup search and result handshake.
module stli_ctrl
    import stli_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_opcode,
    input  t_stat                     i_stat,
    input  logic signed [PULSE_W-1:0] i_rd_pulse,
    input  logic signed [PULSE_W-1:0] i_quot,
    output t_cmd                      o_cmd,
    output logic [$clog2(DEPTH)-1:0]  o_addr,
    output logic [$clog2(DEPTH)-1:0]  o_waddr,
    output logic signed [PULSE_W-1:0] o_pulse,
    output logic [STATUS_W-1:0]       o_status,
    output logic [6:0]                o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,  // insert: find position
        S_SHIFT = 10'b0000001000,  // insert: move entries up
        S_LSCAN = 10'b0000010000,  // lookup: find first greater
        S_LLO   = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_n, r_i, r_pos;
    logic [1:0]          r_ph;
    logic                r_ovalid;
    logic signed [PULSE_W-1:0] r_pulse;
    t_status             r_status;
    // result item held for the output handshake
    logic signed [PULSE_W-1:0] r_opulse;
    logic [STATUS_W-1:0]       r_ostatus;
    logic [6:0]                r_ocount;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_pulse     = r_opulse;
    assign o_status    = r_ostatus;
    assign o_count     = r_ocount;

    always_comb begin
        o_cmd   = '0;
        o_addr  = r_i[AW-1:0];
        o_waddr = r_i[AW-1:0];
        o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_SHIFT: begin
                o_addr  = AW'(r_i - CW'(1));
                o_waddr = r_i[AW-1:0];
                o_cmd.wr_shift = (r_ph == 2'd1) && (r_i != r_pos);
                o_cmd.wr_new   = (r_ph == 2'd1) && (r_i == r_pos);
            end
            S_LLO: begin
                o_addr = AW'(r_i - CW'(1));
                o_cmd.cap_hi = (r_ph == 2'd0);
                o_cmd.cap_lo = (r_ph == 2'd1);
            end
            S_MUL: o_cmd.div_start = (r_ph == 2'd1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_ovalid || i_out_ready)) begin
                r_ovalid  <= 1'b1;
                r_opulse  <= r_pulse;
                r_ostatus <= r_status;
                r_ocount  <= 7'(r_n);
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state <= S_DISP;
                    r_i     <= '0;
                    r_ph    <= '0;
                end
                S_DISP: begin
                    r_pulse <= '0;
                    if (i_opcode == OP_INSERT) begin
                        if (r_n == CW'(DEPTH)) begin
                            r_status <= ST_DROPPED;
                            r_state  <= S_OUT;
                        end else begin
                            r_pos   <= r_n;
                            r_state <= S_SCAN;
                        end
                    end else if (r_n == '0) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_LSCAN;
                    end
                end
                S_SCAN: begin
                    // address r_i issued; data valid next cycle (r_ph toggles)
                    if (r_i == r_n) begin
                        r_i <= r_n; r_ph <= '0; r_state <= S_SHIFT;
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (i_stat.rd_gt) begin
                        r_pos <= r_i; r_i <= r_n; r_ph <= '0; r_state <= S_SHIFT;
                    end else begin
                        r_i <= r_i + CW'(1); r_ph <= '0;
                    end
                end
                S_SHIFT: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_i == r_pos) begin
                        r_n      <= r_n + CW'(1);
                        r_status <= ST_INSERTED;
                        r_state  <= S_OUT;
                    end else begin
                        r_i <= r_i - CW'(1); r_ph <= '0;
                    end
                end
                S_LSCAN: begin
                    if (r_i == r_n) begin
                        r_ph <= 2'd0; r_state <= S_WAIT;
                        r_i  <= r_n - CW'(1);
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (i_stat.rd_gt) begin
                        if (r_i == '0) begin
                            r_pulse  <= i_rd_pulse;
                            r_status <= ST_LOW;
                            r_state  <= S_OUT;
                        end else begin
                            r_ph <= 2'd0; r_state <= S_LLO;
                        end
                    end else begin
                        r_i <= r_i + CW'(1); r_ph <= '0;
                    end
                end
                S_LLO: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin r_ph <= 2'd0; r_state <= S_MUL; end
                end
                S_MUL: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else r_state <= S_DIV;
                end
                S_DIV: if (i_stat.div_done) begin
                    r_pulse  <= i_quot;
                    r_status <= ST_INTERP;
                    r_state  <= S_OUT;
                end
                S_WAIT: begin
                    // read last entry for clamp high
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin
                        r_pulse  <= i_rd_pulse;
                        r_status <= ST_HIGH;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: if (!r_ovalid || i_out_ready) begin
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/sorted_table_linear_interpolator.sv @@
// Top level of the sorted-table piecewise-linear interpolator.
// channel | dir | payload
// in      | in  | opcode, energy, pulse_value
// out     | out | pulse_out, status, entry_count, table_nonempty
// One item at a time; an insert scans for its position, then shifts the entries above it up.
// Lookup scans for the first greater entry, then clamps, or captures both points, multiplies and divides.
// Reset clears the count, the state and the output valid; memory contents are undefined until written.
// A stalled output holds; the next item is taken once the result is registered.
module sorted_table_linear_interpolator
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stli_in_if.sink      i_in,
    stli_out_if.source   o_out
);
    localparam int AW = $clog2(TABLE_DEPTH);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [AW-1:0] w_addr, w_waddr;
    logic signed [PULSE_W-1:0] w_rd_pulse, w_quot;
    logic w_op;
    logic [6:0] w_count;

    stli_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_addr(w_addr),
        .i_waddr(w_waddr), .i_opcode(i_in.opcode), .i_energy(i_in.energy),
        .i_pulse_value(i_in.pulse_value), .o_stat(w_stat),
        .o_rd_pulse(w_rd_pulse), .o_quot(w_quot), .o_opcode(w_op));

    stli_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready), .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready), .i_opcode(w_op), .i_stat(w_stat),
        .i_rd_pulse(w_rd_pulse), .i_quot(w_quot), .o_cmd(w_cmd),
        .o_addr(w_addr), .o_waddr(w_waddr), .o_pulse(o_out.pulse_out),
        .o_status(o_out.status), .o_count(w_count));

    assign o_out.entry_count    = w_count;
    assign o_out.table_nonempty = (w_count != 7'd0);
endmodule

@@ bench/stli_checker.sv @@
// Checker for the sorted-table interpolator: predicts every result and compares it.
`timescale 1ns / 1ps
module stli_checker
    import stli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    stli_in_if          i_in,
    stli_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic signed [PULSE_W-1:0] pulse;
        logic [STATUS_W-1:0]       status;
        logic [6:0]                count;
        logic                      nonempty;
    } t_result;

    logic [ENERGY_W-1:0]       tbl_energy [DEPTH];
    logic signed [PULSE_W-1:0] tbl_pulse  [DEPTH];
    int                        tbl_size;
    t_result                   expected_results [$];

    function automatic logic signed [PULSE_W-1:0] lerp(int idx, logic [ENERGY_W-1:0] x);
        longint den, num, diff, total;
        den   = longint'(tbl_energy[idx]) - longint'(tbl_energy[idx-1]);
        num   = longint'(x) - longint'(tbl_energy[idx-1]);
        diff  = longint'(tbl_pulse[idx]) - longint'(tbl_pulse[idx-1]);
        total = longint'(tbl_pulse[idx-1]) * den + diff * num;
        return PULSE_W'(total / den);
    endfunction

    function automatic t_result predict_table_item(logic op, logic [ENERGY_W-1:0] e,
                                                   logic signed [PULSE_W-1:0] pv);
        t_result r;
        int pos;
        r.pulse = '0;
        if (op == OP_INSERT) begin
            if (tbl_size >= DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                pos = tbl_size;
                for (int i = 0; i < tbl_size; i++) begin
                    if (tbl_energy[i] > e) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = tbl_size; i > pos; i--) begin
                    tbl_energy[i] = tbl_energy[i-1];
                    tbl_pulse[i]  = tbl_pulse[i-1];
                end
                tbl_energy[pos] = e;
                tbl_pulse[pos]  = pv;
                tbl_size++;
                r.status = ST_INSERTED;
            end
        end else if (tbl_size == 0) begin
            r.status = ST_EMPTY;
        end else if (e < tbl_energy[0]) begin
            r.pulse  = tbl_pulse[0];
            r.status = ST_LOW;
        end else begin
            r.pulse  = tbl_pulse[tbl_size-1];
            r.status = ST_HIGH;
            for (int i = 1; i < tbl_size; i++) begin
                if (e < tbl_energy[i]) begin
                    r.pulse  = lerp(i, e);
                    r.status = ST_INTERP;
                    break;
                end
            end
        end
        r.count    = 7'(tbl_size);
        r.nonempty = (tbl_size > 0);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            tbl_size <= 0;
            o_fail_count <= 0;
            o_results <= 0;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(
                    predict_table_item(i_in.opcode, i_in.energy, i_in.pulse_value));
            if (i_out.valid && i_out.ready) begin
                got = {i_out.pulse_out, i_out.status, i_out.entry_count, i_out.table_nonempty};
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected pulse %0d status %0d count %0d ne %0d,",
                                 $time, exp_r.pulse, exp_r.status, exp_r.count, exp_r.nonempty);
                        $display("    actual pulse %0d status %0d count %0d ne %0d",
                                 got.pulse, got.status, got.count, got.nonempty);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/tb_top.sv @@
// Testbench top: drives insert and lookup items into the interpolator and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import stli_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     fail_count, pending, results;
    int     n_inserts, n_lookups;
    longint cycles = 0;
    logic [ENERGY_W-1:0] energies [$];

    stli_in_if  in_ch();
    stli_out_if out_ch();

    sorted_table_linear_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    stli_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver back-pressure, with quiet spells of no stalling
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                out_ch.ready = 1'b1;
                repeat ($urandom_range(100, 600)) @(negedge i_clk);
            end
            n = gap_len();
            if (n > 0) begin
                out_ch.ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
        end
    end

    task automatic send_item(logic op, logic [ENERGY_W-1:0] e, logic signed [PULSE_W-1:0] pv);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.opcode      = op;
        in_ch.energy      = e;
        in_ch.pulse_value = pv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        if (op == OP_INSERT) begin
            n_inserts++;
            energies.push_back(e);
        end else begin
            n_lookups++;
        end
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [ENERGY_W-1:0] pick_energy();
        int r;
        logic [ENERGY_W-1:0] e;
        r = $urandom_range(0, 9);
        if (r < 4 && energies.size() > 0) begin
            e = energies[$urandom_range(0, energies.size() - 1)];
            if (r == 1) e = e + 1;
            if (r == 2) e = e - 1;
            return e;
        end
        if (r == 9) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return ENERGY_W'($urandom());
    endfunction

    function automatic logic signed [PULSE_W-1:0] pick_pulse();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return PULSE_W'($urandom_range(0, 2000)) - 1000;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_INSERT;
        in_ch.energy      = '0;
        in_ch.pulse_value = '0;
        n_inserts = 0;
        n_lookups = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, single point, duplicates, extremes
        send_item(OP_LOOKUP, 24'h00_1234, 0);
        send_item(OP_INSERT, 24'h10_0000, 32'sd500);
        send_item(OP_LOOKUP, 24'h0F_FFFF, 0);
        send_item(OP_LOOKUP, 24'h10_0000, 0);
        send_item(OP_LOOKUP, 24'hFF_FFFF, 0);
        send_item(OP_INSERT, 24'h00_0000, 32'sh8000_0000);
        send_item(OP_INSERT, 24'hFF_FFFF, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 24'h10_0000, -32'sd700);
        send_item(OP_LOOKUP, 24'h00_0000, 0);
        send_item(OP_LOOKUP, 24'h08_0001, 0);
        send_item(OP_LOOKUP, 24'h10_0000, 0);
        send_item(OP_LOOKUP, 24'h80_0000, 32'sh7FFF_FFFF);
        send_item(OP_LOOKUP, 24'hFF_FFFE, 0);
        send_item(OP_LOOKUP, 24'hFF_FFFF, 0);
        send_item(OP_INSERT, 24'h00_0000, 32'sd3);
        send_item(OP_LOOKUP, 24'h00_0000, 0);
        drain();

        // random phases: fill towards full, overflow, then lookups
        while (n_inserts + n_lookups < 1050) begin
            if (energies.size() >= 64) begin
                repeat ($urandom_range(1, 4)) send_item(OP_INSERT, pick_energy(), pick_pulse());
                repeat (40) send_item(OP_LOOKUP, pick_energy(), pick_pulse());
                drain();
                // table keeps its points; continue with lookups
                repeat (150) send_item(OP_LOOKUP, pick_energy(), pick_pulse());
                break;
            end
            if ($urandom_range(0, 2) == 0)
                send_item(OP_INSERT, pick_energy(), pick_pulse());
            else
                send_item(OP_LOOKUP, pick_energy(), pick_pulse());
        end
        while (n_inserts + n_lookups < 1050) begin
            send_item($urandom_range(0, 4) == 0 ? OP_INSERT : OP_LOOKUP,
                      pick_energy(), pick_pulse());
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("covered %0d inserts and %0d lookups, %0d results checked",
                 n_inserts, n_lookups, results);
        $display("table filled past its depth, with clamped, empty and interpolated lookups");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
